// ----- hdl/maf_pkg.sv -----
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and codes for the moving average filter core.
// ----------------------------------------------------------------------------
package maf_pkg;

    // Width of the window size register
    localparam int WIN_W = 7;

    // Item kinds carried on the input tuser
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef logic [WIN_W-1:0] t_win;

endpackage

// ----- hdl/maf_ram.sv -----
// ----------------------------------------------------------------------------
// maf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/moving_average_filter_core.sv -----
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Boxcar moving average over a programmable window, samples held in a RAM.
// ----------------------------------------------------------------------------
// One item is processed at a time. A push reads the overwritten sample from
// the RAM on accept, then updates the running sum and writes the new sample
// back, then runs the one-bit-per-cycle divider over all SUM_W bits of the
// sum (SUM_W = SAMPLE_BITS + clog2(window cap)), then saturates and hands
// the result over once the output register is free. A clear item, or any
// item while the window is 0, skips the sum and divider and returns 0. The
// result register frees the input side, so the next item is accepted while
// a result still waits on the output. The window size should only be
// written while no item is in flight; clear the filter after a window
// change. Windows above MAX_WINDOW act as MAX_WINDOW. No clearing pass is
// needed after reset: entries past the fill count read as zero.
// ----------------------------------------------------------------------------
module moving_average_filter_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    localparam int DW         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [maf_pkg::WIN_W-1:0] i_cfg_wdata,
    // input items
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [DW-1:0]           i_s_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                    i_s_tuser,  // [0] op
    // result items
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [DW-1:0]           o_m_tdata   // [SAMPLE_BITS-1:0] average
);

    localparam int WIN_W = maf_pkg::WIN_W;
    localparam int WMAX  = (1 << WIN_W) - 1;
    localparam int WCAP  = (MAX_WINDOW < WMAX) ? MAX_WINDOW : WMAX;
    localparam int SUM_W = SAMPLE_BITS + $clog2(WCAP);
    localparam int AW    = (WCAP > 1) ? $clog2(WCAP) : 1;
    localparam int PW    = $clog2(WCAP + 1);
    localparam int CW    = $clog2(SUM_W + 1);

    // FSM codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_RES  = 3'd3;

    localparam logic [SUM_W-1:0] HI_MAG = SUM_W'({(SAMPLE_BITS-1){1'b1}});
    localparam logic [SUM_W-1:0] LO_MAG = HI_MAG + 1'b1;

    logic [2:0]                    r_state, n_state;
    maf_pkg::t_win                 r_win;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [PW-1:0]                 r_pos, n_pos;
    logic [PW-1:0]                 r_fill, n_fill;
    logic [PW-1:0]                 r_p;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    maf_pkg::t_win                 r_dvs;
    logic [SUM_W-1:0]              r_quo, n_quo;
    logic [WIN_W-1:0]              r_rem, n_rem;
    logic [CW-1:0]                 r_cnt, n_cnt;
    logic                          r_neg, n_neg;
    logic                          r_zero, n_zero;
    logic                          r_m_valid;
    logic [SAMPLE_BITS-1:0]        r_m_data;

    maf_pkg::t_win                 w_c;
    logic [PW-1:0]                 p_c;
    logic                          in_acc;
    logic                          out_free;
    logic [SAMPLE_BITS-1:0]        rd_data;
    logic signed [SUM_W-1:0]       old_c;
    logic signed [SUM_W-1:0]       sum_c;
    logic [WIN_W:0]                rem_sh;
    logic                          ge;
    logic [WIN_W:0]                rem_sub;
    logic [SUM_W-1:0]              neg_q;
    logic [SAMPLE_BITS-1:0]        res_c;

    // Active window, capped at the store depth
    assign w_c = (r_win > WIN_W'(WCAP)) ? WIN_W'(WCAP) : r_win;

    // Write position wraps before the write once it reaches the window
    assign p_c = (WIN_W'(r_pos) >= w_c) ? '0 : r_pos;

    assign o_s_tready = (r_state == ST_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    // Sample store
    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WCAP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_UPD),
        .i_waddr (r_p[AW-1:0]),
        .i_wdata (r_smp),
        .i_re    (in_acc),
        .i_raddr (p_c[AW-1:0]),
        .o_rdata (rd_data)
    );

    // Overwritten sample counts only if written since the last clear
    assign old_c = (r_p < r_fill) ? SUM_W'(signed'(rd_data)) : '0;
    assign sum_c = r_sum - old_c + SUM_W'(r_smp);

    // One restoring division step
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // Sign restore and saturation of the quotient
    assign neg_q = SUM_W'(0) - r_quo;
    always_comb begin
        if (r_zero) begin
            res_c = '0;
        end else if (r_neg) begin
            res_c = (r_quo > LO_MAG) ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : neg_q[SAMPLE_BITS-1:0];
        end else begin
            res_c = (r_quo > HI_MAG) ? {1'b0, {(SAMPLE_BITS-1){1'b1}}}
                                     : r_quo[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_sum   = r_sum;
        n_pos   = r_pos;
        n_fill  = r_fill;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zero  = r_zero;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_s_tuser == maf_pkg::OP_CLEAR) begin
                        n_sum   = '0;
                        n_pos   = '0;
                        n_fill  = '0;
                        n_zero  = 1'b1;
                        n_state = ST_RES;
                    end else if (w_c == '0) begin
                        n_zero  = 1'b1;
                        n_state = ST_RES;
                    end else begin
                        n_zero  = 1'b0;
                        n_state = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                n_sum   = sum_c;
                n_pos   = r_p + 1'b1;
                n_fill  = (r_fill < r_p + 1'b1) ? r_p + 1'b1 : r_fill;
                n_neg   = sum_c[SUM_W-1];
                n_quo   = sum_c[SUM_W-1] ? SUM_W'(0) - sum_c : sum_c;
                n_rem   = '0;
                n_cnt   = CW'(SUM_W);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_quo = {r_quo[SUM_W-2:0], ge};
                n_rem = ge ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = ST_RES;
                end
            end
            ST_RES: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_win     <= '0;
            r_sum     <= '0;
            r_pos     <= '0;
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            if (r_state == ST_RES && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        if (in_acc) begin
            r_p   <= p_c;
            r_smp <= signed'(i_s_tdata[SAMPLE_BITS-1:0]);
            r_dvs <= w_c;
        end
        if (r_state == ST_RES && out_free) begin
            r_m_data <= res_c;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = DW'(r_m_data);

endmodule

// ----- hdl/maf_checker.sv -----
// ----------------------------------------------------------------------------
// maf_port_checks
// Port-level checks for the moving average filter core, bound to the top.
// ----------------------------------------------------------------------------
module maf_port_checks #(
    parameter int SAMPLE_BITS = 16,
    localparam int DW         = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_we,
    input logic [maf_pkg::WIN_W-1:0] i_cfg_wdata,
    input logic                      i_s_tvalid,
    input logic                      o_s_tready,
    input logic                      i_s_tuser,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [DW-1:0]             o_m_tdata
);

    logic          in_acc, out_acc, zero_c;
    maf_pkg::t_win r_win;
    logic [1:0]    r_cnt, n_cnt;
    logic [1:0]    r_zq, n_zq;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;
    assign zero_c  = (i_s_tuser == maf_pkg::OP_CLEAR) || (r_win == '0);

    // Items in flight, with a flag per item telling whether its result is 0
    always_comb begin
        n_cnt = r_cnt;
        n_zq  = r_zq;
        if (out_acc) begin
            n_zq[0] = r_zq[1];
            n_cnt   = r_cnt - 1'b1;
        end
        if (in_acc) begin
            n_zq[n_cnt[0]] = zero_c;
            n_cnt          = n_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_cnt <= '0;
            r_zq  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_zq  <= n_zq;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
        end
    end

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No result without an item behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> r_cnt != 2'd0)
        else $error("result with no item in flight");

    // At most one item in the core and one in the output register
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2) && (!o_s_tready || (r_cnt <= 2'd1)))
        else $error("too many items in flight");

    // Clear items and a zero window give a zero average
    a_zero_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_zq[0] |-> o_m_tdata == '0)
        else $error("nonzero average for clear or zero window");

endmodule

bind moving_average_filter_core maf_port_checks #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_maf_port_checks (.*);

// ----- tb/maf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_checker
// Watches the window register writes, input items and result items of the
// moving average core. It keeps its own ring of samples and running sum,
// predicts the average for every accepted input item, and compares each
// accepted result with the oldest predicted average.
// ----------------------------------------------------------------------------
module maf_checker #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  maf_pkg::t_win          i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                   i_s_tuser,   // [0] op
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [SAMPLE_BITS-1:0] i_m_tdata,   // [SAMPLE_BITS-1:0] average
    output int                     o_errors,
    output int                     o_pending
);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int     PRINT_CAP = 40;

    // Shadow copy of the filter state
    t_sample       ring [MAX_WINDOW];
    longint        ring_sum;
    int            wr_pos;
    int            filled;
    maf_pkg::t_win win_reg;

    // Averages predicted but not yet returned, oldest first
    t_sample       pending_averages [$];

    initial o_errors = 0;
    initial o_pending = 0;

    task automatic report_mismatch(input string what);
        if (o_errors < PRINT_CAP) begin
            $display("[%0t] maf_checker: %s", $time, what);
        end
        o_errors++;
    endtask

    // Apply one item to the shadow state and return its average
    function automatic t_sample next_average(input logic op, input t_sample smp);
        int     w;
        longint avg;
        w   = (win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg);
        avg = 0;
        if (op == maf_pkg::OP_CLEAR) begin
            ring_sum = 0;
            wr_pos   = 0;
            filled   = 0;
        end else if (w != 0) begin
            // position left past a shrunk window wraps before the write
            if (wr_pos >= w) begin
                wr_pos = 0;
            end
            // entries beyond the fill count read as zero
            if (wr_pos < filled) begin
                ring_sum -= longint'(ring[wr_pos]);
            end
            ring[wr_pos] = smp;
            ring_sum += longint'(smp);
            wr_pos++;
            if (filled < wr_pos) begin
                filled = wr_pos;
            end
        end
        if (w != 0) begin
            avg = ring_sum / longint'(w);
            if (avg > SAT_HI) begin
                avg = SAT_HI;
            end
            if (avg < SAT_LO) begin
                avg = SAT_LO;
            end
        end
        return t_sample'(avg);
    endfunction

    // Channel monitor: results are checked before new items are predicted
    always @(posedge i_clk) begin
        t_sample want;
        if (!i_rst_n) begin
            win_reg  = '0;
            ring_sum = 0;
            wr_pos   = 0;
            filled   = 0;
            pending_averages.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_averages.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, average %0d",
                                              $signed(i_m_tdata)));
                end else begin
                    want = pending_averages.pop_front();
                    if (i_m_tdata !== want) begin
                        report_mismatch($sformatf("average got %0d want %0d",
                                                  $signed(i_m_tdata), want));
                    end
                end
            end
            if (i_cfg_we) begin
                win_reg = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_averages.push_back(next_average(i_s_tuser, t_sample'(i_s_tdata)));
            end
        end
        o_pending <= pending_averages.size();
    end

endmodule

// ----- tb/moving_average_filter_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_core_tb
// Drives the moving average core with directed corner items (sample
// extremes, clears, a disabled window, saturation after a window shrink,
// a window above the cap) and then with random phases of pushes and clears
// under several window sizes, with bursty input and a stalling output side.
// The checker beside the core predicts and compares every average.
// ----------------------------------------------------------------------------
module moving_average_filter_core_tb;

    localparam int IDLE_LIMIT    = 4000;   // cycles without any accepted item
    localparam int SETTLE_CYCLES = 40;     // extra wait after the last result
    localparam int HOLD_CYCLES   = 300;    // long output hold-off
    localparam int RANDOM_ITEMS  = 1400;
    localparam int MAX_WINDOW    = 64;

    localparam logic [15:0] S_MAX = 16'sh7fff;
    localparam logic [15:0] S_MIN = 16'sh8000;

    // Output-side stall patterns
    typedef enum int { RX_OPEN, RX_MOSTLY_READY, RX_MOSTLY_STALLED, RX_PULSED } t_rx_mode;

    logic          i_clk     = 1'b0;
    logic          i_rst_n   = 1'b0;
    logic          cfg_we    = 1'b0;
    maf_pkg::t_win cfg_wdata = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [15:0]   s_tdata   = '0;
    logic          s_tuser   = maf_pkg::OP_PUSH;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [15:0]   m_tdata;

    int            chk_errors;
    int            chk_pending;
    int            burst_left  = 0;
    int            sent_items  = 0;
    int            hold_req    = 0;
    int            hold_seen   = 0;
    int            hold_left   = 0;
    int            idle_cycles = 0;
    t_rx_mode      rx_mode     = RX_OPEN;
    int            rx_left     = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    moving_average_filter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    maf_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    // Result side: random stall patterns, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
                rx_left <= $urandom_range(8, 80);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:           m_tready <= 1'b1;
                RX_MOSTLY_READY:   m_tready <= ($urandom_range(0, 9) < 7);
                RX_MOSTLY_STALLED: m_tready <= ($urandom_range(0, 9) < 2);
                default:           m_tready <= ((rx_left % 8) < 3);
            endcase
        end
    end

    // Watchdog on cycles with no accepted item on either side
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("moving_average_filter_core_tb: errors");
            $finish;
        end
    end

    // Offer one item, with a random gap before each new burst
    task automatic send_item(input logic op, input logic [15:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= smp;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        burst_left--;
        sent_items++;
    endtask

    // Stop offering and wait until every predicted average has come back
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(input int w);
        cfg_we    <= 1'b1;
        cfg_wdata <= maf_pkg::t_win'(w);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly random samples, with the extremes and small values mixed in
    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'(signed'($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int pick_window();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return MAX_WINDOW;
            3:       return $urandom_range(MAX_WINDOW + 1, 127);
            4:       return 127;
            default: return $urandom_range(2, MAX_WINDOW - 1);
        endcase
    endfunction

    initial begin
        int n;
        int phase;
        phase = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Sample extremes, clear, truncation of a negative sum toward zero
        set_window(4);
        send_item(maf_pkg::OP_PUSH, 16'h0000);
        send_item(maf_pkg::OP_PUSH, S_MAX);
        send_item(maf_pkg::OP_PUSH, S_MIN);
        send_item(maf_pkg::OP_PUSH, 16'hffff);
        send_item(maf_pkg::OP_PUSH, 16'h0001);
        send_item(maf_pkg::OP_CLEAR, 16'h5a5a);
        send_item(maf_pkg::OP_PUSH, 16'd5);
        send_item(maf_pkg::OP_PUSH, -16'sd7);

        // Disabled window ignores pushes and returns zero
        drain_results();
        set_window(0);
        send_item(maf_pkg::OP_PUSH, 16'd123);
        send_item(maf_pkg::OP_CLEAR, 16'h0000);
        send_item(maf_pkg::OP_PUSH, -16'sd5);

        // Shrink from two to one with a full sum: saturates high
        drain_results();
        set_window(2);
        send_item(maf_pkg::OP_CLEAR, 16'hffff);
        send_item(maf_pkg::OP_PUSH, S_MAX);
        send_item(maf_pkg::OP_PUSH, S_MAX);
        drain_results();
        set_window(1);
        send_item(maf_pkg::OP_PUSH, S_MAX);

        // Same shrink on the negative side: saturates low
        drain_results();
        set_window(2);
        send_item(maf_pkg::OP_CLEAR, 16'h0000);
        send_item(maf_pkg::OP_PUSH, S_MIN);
        send_item(maf_pkg::OP_PUSH, S_MIN);
        drain_results();
        set_window(1);
        send_item(maf_pkg::OP_PUSH, S_MIN);

        // Window above the cap acts as the cap; unwritten entries count as zero
        drain_results();
        set_window(127);
        send_item(maf_pkg::OP_CLEAR, 16'h0000);
        send_item(maf_pkg::OP_PUSH, 16'd1000);
        send_item(maf_pkg::OP_PUSH, -16'sd3);

        // Random phases: new window, usually a clear, then a run of items
        while (sent_items < RANDOM_ITEMS + 25) begin
            drain_results();
            set_window(pick_window());
            if (phase == 2 || phase == 9) begin
                hold_req <= hold_req + 1;
            end
            if ($urandom_range(0, 4) != 0) begin
                send_item(maf_pkg::OP_CLEAR, rand_sample());
            end
            n = $urandom_range(20, 90);
            repeat (n) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_item(maf_pkg::OP_CLEAR, rand_sample());
                end else begin
                    send_item(maf_pkg::OP_PUSH, rand_sample());
                end
            end
            phase++;
        end

        drain_results();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("moving_average_filter_core_tb: clean");
        end else begin
            $display("moving_average_filter_core_tb: errors");
        end
        $finish;
    end

endmodule
